// File: hdl/mrs_pkg.sv
// shared constants, state encoding and crc helper for the modbus rtu slave engine
// no dependencies
`default_nettype none
package mrs_pkg;

	localparam int FRAME_BYTES   = 64;
	localparam int STORE_BYTES   = 256;
	localparam int MAX_READ_REGS = 29;
	localparam int MIN_FRAME     = 8;
	localparam int MAX_REPLY     = 64;
	localparam int ONE_DATA_AT   = 4;
	localparam int MUL_DATA_AT   = 7;
	localparam int HDR_BYTES     = 7;

	localparam int FB_AW = $clog2(FRAME_BYTES);
	localparam int ST_AW = $clog2(STORE_BYTES);
	localparam int FC_W  = $clog2(FRAME_BYTES + 1);

	localparam logic [7:0] FC_READ_HOLD = 8'd3;
	localparam logic [7:0] FC_READ_IN   = 8'd4;
	localparam logic [7:0] FC_WRITE_ONE = 8'd6;
	localparam logic [7:0] FC_WRITE_MUL = 8'd16;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_EOF  = 1'b1;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_RD,
		ST_DATA,
		ST_CRC_LO,
		ST_CRC_HI
	} mrs_state_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// File: hdl/mrs_if.sv
// stream and configuration channel interfaces for the modbus rtu slave engine
// no dependencies
`default_nettype none
interface mrs_rx_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_byte;
	modport source (output valid, output opcode, output rx_byte, input ready);
	modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface mrs_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last;
	modport source (output valid, output tx_byte, output last, input ready);
	modport sink (input valid, input tx_byte, input last, output ready);
endinterface

interface mrs_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/modbus_rtu_slave_register_engine.sv
// modbus rtu slave register engine: frame buffer, crc check and register store
// depends on mrs_pkg and the channel interfaces in mrs_if.sv
// received byte: one transaction per cycle, no result; the input waits while a reply is out
// end of frame: the frame is judged as the marker is taken, then the header bytes, the data bytes
//   (memory read state, then emit state) and the two crc bytes go out, each waiting for a free output slot
// reset clears the frame state, sets the slave address to 1; unwritten store bytes read as 0
`default_nettype none
module modbus_rtu_slave_register_engine import mrs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	mrs_rx_if.sink    rx_ch,
	mrs_tx_if.source  tx_ch,
	mrs_cfg_if.sink   cfg
);

	// configuration
	logic [7:0] slave_addr_q;

	// frame reception state
	logic [FC_W-1:0] count_q;
	logic            ovf_q;
	logic [15:0]     crc_q;
	logic [7:0]      hdr_q [HDR_BYTES];

	// memories
	logic [7:0] fb_mem [FRAME_BYTES];
	logic [7:0] st_mem [STORE_BYTES];
	logic [STORE_BYTES-1:0] st_vld_q;
	logic [7:0] fb_rd_q;
	logic [7:0] st_rd_q;
	logic       st_rd_vld_q;

	// reply sequencer
	mrs_state_t      state_q, state_d;
	logic [1:0]      hidx_q;
	logic [1:0]      hlast_q;
	logic            is_wr_q;
	logic [5:0]      dcnt_q;
	logic [ST_AW-1:0] st_ptr_q;
	logic [FB_AW-1:0] fb_ptr_q;
	logic [15:0]     rcrc_q;

	// output register
	logic       ovalid_q;
	logic [7:0] obyte_q;
	logic       olast_q;

	logic rx_take, rx_byte_take, eof_take, slot_free;
	logic emit, emit_last, rd_en, wr_en;
	logic [7:0] emit_byte;

	assign cfg.ready   = 1'b1;
	assign rx_ch.ready = (state_q == ST_IDLE);
	assign rx_take     = rx_ch.valid && rx_ch.ready;
	assign rx_byte_take = rx_take && (rx_ch.opcode == OP_BYTE);
	assign eof_take     = rx_take && (rx_ch.opcode == OP_EOF);
	assign slot_free   = !ovalid_q || tx_ch.ready;

	assign tx_ch.valid   = ovalid_q;
	assign tx_ch.tx_byte = obyte_q;
	assign tx_ch.last    = olast_q;

	// frame judgment from header registers
	logic [15:0] addr16, n16;
	logic [7:0]  code, wcnt;
	logic [FB_AW-1:0] src;
	logic        base_ok, is_rd, is_wr, rd_ok, wr_ok, answer;
	logic [17:0] rd_end;
	logic [16:0] wr_end;
	logic [8:0]  wr_need;

	always_comb begin
		addr16  = {hdr_q[2], hdr_q[3]};
		n16     = {hdr_q[4], hdr_q[5]};
		code    = hdr_q[1];
		base_ok = !ovf_q && (count_q >= FC_W'(MIN_FRAME)) &&
			(hdr_q[0] == slave_addr_q) && (crc_q == 16'h0000);
		is_rd   = (code == FC_READ_HOLD) || (code == FC_READ_IN);
		is_wr   = (code == FC_WRITE_ONE) || (code == FC_WRITE_MUL);
		// read end address, only meaningful once the count is bounded
		rd_end  = {2'b00, addr16} + {11'd0, n16[5:0], 1'b0};
		rd_ok   = (n16 <= 16'(MAX_READ_REGS)) && (rd_end <= 18'(STORE_BYTES));
		wcnt    = (code == FC_WRITE_ONE) ? 8'd2 : hdr_q[6];
		src     = (code == FC_WRITE_ONE) ? FB_AW'(ONE_DATA_AT) : FB_AW'(MUL_DATA_AT);
		wr_need = {1'b0, wcnt} + 9'(src) + 9'd2;
		wr_end  = {1'b0, addr16} + {9'd0, wcnt};
		wr_ok   = (wr_need <= 9'(count_q)) && (wcnt <= 8'(MAX_REPLY - 6)) &&
			(wr_end <= 17'(STORE_BYTES));
		answer  = base_ok && ((is_rd && rd_ok) || (is_wr && wr_ok));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (eof_take && answer) state_d = ST_HDR;
			end
			ST_HDR: begin
				if (slot_free && hidx_q == hlast_q) begin
					state_d = (dcnt_q == 6'd0) ? ST_CRC_LO : ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_DATA;
			end
			ST_DATA: begin
				if (slot_free) state_d = (dcnt_q == 6'd1) ? ST_CRC_LO : ST_RD;
			end
			ST_CRC_LO: begin
				if (slot_free) state_d = ST_CRC_HI;
			end
			ST_CRC_HI: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		emit      = 1'b0;
		emit_last = 1'b0;
		emit_byte = 8'h00;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_HDR: begin
				emit = slot_free;
				unique case (hidx_q)
					2'd0: emit_byte = hdr_q[0];
					2'd1: emit_byte = hdr_q[1];
					2'd2: emit_byte = is_wr_q ? hdr_q[2] : {2'b00, dcnt_q};
					2'd3: emit_byte = hdr_q[3];
					default: emit_byte = 8'h00;
				endcase
			end
			ST_RD: begin
				rd_en = 1'b1;
			end
			ST_DATA: begin
				emit      = slot_free;
				wr_en     = slot_free && is_wr_q;
				emit_byte = is_wr_q ? fb_rd_q : (st_rd_vld_q ? st_rd_q : 8'h00);
			end
			ST_CRC_LO: begin
				emit      = slot_free;
				emit_byte = rcrc_q[7:0];
			end
			ST_CRC_HI: begin
				emit      = slot_free;
				emit_last = 1'b1;
				emit_byte = rcrc_q[15:8];
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= 8'd1;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			crc_q        <= CRC_INIT;
			state_q      <= ST_IDLE;
			ovalid_q     <= 1'b0;
			st_vld_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) slave_addr_q <= cfg.data;
			if (rx_byte_take) begin
				if (count_q < FC_W'(FRAME_BYTES)) begin
					count_q <= count_q + FC_W'(1);
					crc_q   <= crc_byte(crc_q, rx_ch.rx_byte);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			// every end of frame returns the frame state to its reset values
			if (eof_take) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				crc_q   <= CRC_INIT;
			end
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (tx_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			if (wr_en) st_vld_q[st_ptr_q] <= 1'b1;
		end
	end

	// payload registers and sequencer counters
	always_ff @(posedge clk) begin
		if (rx_byte_take && count_q < FC_W'(HDR_BYTES)) begin
			hdr_q[count_q[2:0]] <= rx_ch.rx_byte;
		end
		if (eof_take) begin
			hidx_q   <= 2'd0;
			hlast_q  <= is_wr ? 2'd3 : 2'd2;
			is_wr_q  <= is_wr;
			dcnt_q   <= is_wr ? wcnt[5:0] : {n16[4:0], 1'b0};
			st_ptr_q <= addr16[ST_AW-1:0];
			fb_ptr_q <= src;
			rcrc_q   <= CRC_INIT;
		end
		if (emit) begin
			obyte_q <= emit_byte;
			olast_q <= emit_last;
			if (state_q == ST_HDR || state_q == ST_DATA) begin
				rcrc_q <= crc_byte(rcrc_q, emit_byte);
			end
		end
		if (state_q == ST_HDR && emit) hidx_q <= hidx_q + 2'd1;
		if (state_q == ST_DATA && emit) begin
			dcnt_q   <= dcnt_q - 6'd1;
			st_ptr_q <= st_ptr_q + ST_AW'(1);
			fb_ptr_q <= fb_ptr_q + FB_AW'(1);
		end
	end

	// frame buffer memory
	always_ff @(posedge clk) begin
		if (rx_byte_take && count_q < FC_W'(FRAME_BYTES)) begin
			fb_mem[count_q[FB_AW-1:0]] <= rx_ch.rx_byte;
		end
		if (rd_en) fb_rd_q <= fb_mem[fb_ptr_q];
	end

	// register store memory
	always_ff @(posedge clk) begin
		if (wr_en) st_mem[st_ptr_q] <= fb_rd_q;
		if (rd_en) begin
			st_rd_q     <= st_mem[st_ptr_q];
			st_rd_vld_q <= st_vld_q[st_ptr_q];
		end
	end

endmodule
`default_nettype wire

// File: dv/mrs_checker.sv
// watches the receive, transmit and configuration channels of the modbus rtu slave engine,
// predicts the response bytes and compares them in order
// depends on mrs_pkg and the channel interfaces in mrs_if.sv
`timescale 1ns / 1ps
`default_nettype none
module mrs_checker import mrs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic rx_valid,
	input  wire logic rx_ready,
	input  wire logic rx_opcode,
	input  wire logic [7:0] rx_byte,
	input  wire logic tx_valid,
	input  wire logic tx_ready,
	input  wire logic [7:0] tx_byte,
	input  wire logic tx_last,
	input  wire logic cfg_valid,
	input  wire logic cfg_ready,
	input  wire logic [7:0] cfg_data,
	output int        fail_count,
	output int        pending_bytes
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} resp_byte_t;

	resp_byte_t  resp_q[$];
	logic [7:0]  own_addr;
	logic [7:0]  frame_mem [FRAME_BYTES];
	int          frame_len;
	logic        frame_ovf;
	logic [15:0] frame_crc;
	logic [7:0]  store_mem [STORE_BYTES];

	assign pending_bytes = resp_q.size();

	function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
		end
		return r;
	endfunction

	task automatic report(input string what, input logic [7:0] got_b, input logic got_l,
			input logic [7:0] exp_b, input logic exp_l);
		$display("%0t tx %s: got %02h/%0d expected %02h/%0d", $realtime, what,
			got_b, got_l, exp_b, exp_l);
		fail_count++;
	endtask

	// judge the buffered frame and queue the response bytes
	task automatic answer_frame();
		logic [7:0]  reply [$];
		logic [7:0]  code;
		logic [15:0] crc;
		int          base, cnt, src;
		if (frame_ovf || frame_len < MIN_FRAME) return;
		if (frame_mem[0] != own_addr || frame_crc != 16'h0) return;
		code = frame_mem[1];
		base = {frame_mem[2], frame_mem[3]};
		if (code == FC_READ_HOLD || code == FC_READ_IN) begin
			cnt = {frame_mem[4], frame_mem[5]};
			if (cnt > MAX_READ_REGS || 5 + 2 * cnt > MAX_REPLY) return;
			if (base + 2 * cnt > STORE_BYTES) return;
			reply.push_back(frame_mem[0]);
			reply.push_back(code);
			reply.push_back(8'(2 * cnt));
			for (int i = 0; i < 2 * cnt; i++) reply.push_back(store_mem[base + i]);
		end else begin
			if (code == FC_WRITE_ONE) begin
				cnt = 2;
				src = ONE_DATA_AT;
			end else if (code == FC_WRITE_MUL) begin
				cnt = frame_mem[6];
				src = MUL_DATA_AT;
			end else begin
				return;
			end
			if (src + cnt + 2 > frame_len || 6 + cnt > MAX_REPLY) return;
			if (base + cnt > STORE_BYTES) return;
			reply.push_back(frame_mem[0]);
			reply.push_back(code);
			reply.push_back(frame_mem[2]);
			reply.push_back(frame_mem[3]);
			for (int i = 0; i < cnt; i++) begin
				store_mem[base + i] = frame_mem[src + i];
				reply.push_back(frame_mem[src + i]);
			end
		end
		crc = 16'hFFFF;
		foreach (reply[i]) crc = crc_step(crc, reply[i]);
		reply.push_back(crc[7:0]);
		reply.push_back(crc[15:8]);
		foreach (reply[i]) resp_q.push_back('{reply[i], i == reply.size() - 1});
	endtask

	always @(posedge clk or negedge arst_n) begin
		resp_byte_t e;
		if (!arst_n) begin
			own_addr <= 8'd1;
			frame_len = 0;
			frame_ovf = 1'b0;
			frame_crc = 16'hFFFF;
			foreach (store_mem[i]) store_mem[i] = 8'h00;
			resp_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) own_addr <= cfg_data;
			if (tx_valid && tx_ready) begin
				if (resp_q.size() == 0) begin
					report("unexpected", tx_byte, tx_last, 8'h00, 1'b0);
				end else begin
					e = resp_q.pop_front();
					if (tx_byte !== e.data) report("byte", tx_byte, tx_last, e.data, e.last);
					else if (tx_last !== e.last) report("last", tx_byte, tx_last, e.data, e.last);
				end
			end
			if (rx_valid && rx_ready) begin
				if (rx_opcode == OP_BYTE) begin
					if (frame_len < FRAME_BYTES) begin
						frame_mem[frame_len] = rx_byte;
						frame_len++;
						frame_crc = crc_step(frame_crc, rx_byte);
					end else begin
						frame_ovf = 1'b1;
					end
				end else begin
					answer_frame();
					frame_len = 0;
					frame_ovf = 1'b0;
					frame_crc = 16'hFFFF;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: dv/tb_modbus_rtu_slave_register_engine.sv
// testbench top for the modbus rtu slave register engine: clock, reset, request frames,
// address changes and random back-pressure; the verdict comes from mrs_checker
// depends on mrs_pkg, mrs_if.sv, the engine and dv/mrs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_modbus_rtu_slave_register_engine;
	import mrs_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_bytes;
	int   items_sent;
	int   quiet_cycles;
	bit   tx_hold;        // long receiver hold-off, driven by its own process
	bit   calm;           // stretch with no idling on either side
	logic [7:0] cur_addr;

	mrs_rx_if  rx_ch ();
	mrs_tx_if  tx_ch ();
	mrs_cfg_if cfg ();

	modbus_rtu_slave_register_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx_ch  (rx_ch),
		.tx_ch  (tx_ch),
		.cfg    (cfg)
	);

	mrs_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_valid      (rx_ch.valid),
		.rx_ready      (rx_ch.ready),
		.rx_opcode     (rx_ch.opcode),
		.rx_byte       (rx_ch.rx_byte),
		.tx_valid      (tx_ch.valid),
		.tx_ready      (tx_ch.ready),
		.tx_byte       (tx_ch.tx_byte),
		.tx_last       (tx_ch.last),
		.cfg_valid     (cfg.valid),
		.cfg_ready     (cfg.ready),
		.cfg_data      (cfg.data),
		.fail_count    (fail_count),
		.pending_bytes (pending_bytes)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		rx_ch.valid = 1'b0;
		rx_ch.opcode = OP_BYTE;
		rx_ch.rx_byte = 8'h00;
		cfg.valid = 1'b0;
		cfg.data = 8'h01;
		tx_ch.ready = 1'b0;
		tx_hold = 1'b0;
		calm = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// receiver: ready drops about a quarter of the time unless calm or held off
	always @(posedge clk) begin
		if (arst_n) begin
			tx_ch.ready <= !tx_hold && (calm || $urandom_range(99) >= 25);
		end
	end

	// watchdog: cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready)
				|| (cfg.valid && cfg.ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one transaction on the receive channel, with a random gap before it
	// valid stays high into the next call unless a gap drops it
	task automatic push_item(input logic op, input logic [7:0] b);
		if (!calm) begin
			while ($urandom_range(99) < 25) begin
				rx_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		rx_ch.valid <= 1'b1;
		rx_ch.opcode <= op;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	// send the bytes, optionally with a correct crc, then the end-of-frame marker
	task automatic send_frame(input logic [7:0] body [$], input bit good_crc);
		logic [15:0] c;
		c = 16'hFFFF;
		foreach (body[i]) begin
			push_item(OP_BYTE, body[i]);
			for (int k = 0; k < 8; k++) begin
				if (k == 0) c = c ^ {8'h00, body[i]};
				c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
			end
		end
		if (good_crc) begin
			push_item(OP_BYTE, c[7:0]);
			push_item(OP_BYTE, c[15:8]);
		end
		push_item(OP_EOF, 8'($urandom()));
	endtask

	// address change only once every queued response byte is out and the engine is quiet
	task automatic set_address(input logic [7:0] a);
		rx_ch.valid <= 1'b0;
		while (pending_bytes != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= a;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		cur_addr = a;
	endtask

	// request with random content; mostly well-formed and in range
	task automatic random_request();
		logic [7:0] body [$];
		int         sel, base, n;
		sel = $urandom_range(99);
		base = $urandom_range(0, 255);
		body.push_back(($urandom_range(99) < 90) ? cur_addr : 8'($urandom()));
		if (sel < 35) begin
			n = $urandom_range(0, 12);
			if ($urandom_range(9) == 0) n = $urandom_range(0, 40);
			if (base + 2 * n > 256 && $urandom_range(3) != 0) base = 256 - 2 * n;
			body.push_back($urandom_range(1) ? FC_READ_HOLD : FC_READ_IN);
			body.push_back(8'(base >> 8) | (($urandom_range(19) == 0) ? 8'h01 : 8'h00));
			body.push_back(8'(base));
			body.push_back(($urandom_range(19) == 0) ? 8'($urandom()) : 8'h00);
			body.push_back(8'(n));
		end else if (sel < 60) begin
			body.push_back(FC_WRITE_ONE);
			body.push_back(8'h00);
			body.push_back(8'(($urandom_range(9) == 0) ? 255 : $urandom_range(0, 254)));
			body.push_back(8'($urandom()));
			body.push_back(8'($urandom()));
		end else if (sel < 90) begin
			n = $urandom_range(0, 10);
			if ($urandom_range(9) == 0) n = $urandom_range(50, 62);
			if (base + n > 256) base = 256 - n;
			body.push_back(FC_WRITE_MUL);
			body.push_back(8'h00);
			body.push_back(8'(base));
			body.push_back(8'h00);
			body.push_back(8'((n + 1) / 2));
			body.push_back(8'(n + (($urandom_range(19) == 0) ? 1 : 0)));
			for (int i = 0; i < n; i++) body.push_back(8'($urandom()));
		end else begin
			// noise: random code and bytes
			n = $urandom_range(0, 12);
			for (int i = 0; i < n; i++) body.push_back(8'($urandom()));
		end
		send_frame(body, $urandom_range(19) != 0);
	endtask

	initial begin
		logic [7:0] body [$];
		items_sent = 0;
		cur_addr = 8'd1;
		@(posedge arst_n);
		@(posedge clk);

		// directed: reset address, write one register at the top of the store, read it back
		calm = 1'b1;
		body = '{8'd1, FC_WRITE_ONE, 8'h00, 8'hFE, 8'hFF, 8'hA5};
		send_frame(body, 1'b1);
		body = '{8'd1, FC_READ_IN, 8'h00, 8'hFE, 8'h00, 8'h01};
		send_frame(body, 1'b1);
		// short frame: end of frame with nothing buffered
		push_item(OP_EOF, 8'hFF);
		calm = 1'b0;

		// extremes of the address register
		set_address(8'd247);
		body = '{8'd247, FC_WRITE_MUL, 8'h00, 8'h00, 8'h00, 8'h02, 8'h04,
			8'h00, 8'hFF, 8'h80, 8'h7F};
		send_frame(body, 1'b1);
		body = '{8'd247, FC_READ_HOLD, 8'h00, 8'h00, 8'h00, 8'h1E};  // read count too large
		send_frame(body, 1'b1);
		body = '{8'd247, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00};         // unknown function code
		send_frame(body, 1'b1);
		body = '{8'd247, FC_READ_HOLD, 8'h00, 8'hFF, 8'h00, 8'h01};  // past the store
		send_frame(body, 1'b1);
		body = '{8'd247, FC_READ_HOLD, 8'h00, 8'h00, 8'h00, 8'h02};  // frame sent without crc bytes
		send_frame(body, 1'b0);

		// buffer overflow: 70 bytes with the address first
		body.delete();
		body.push_back(8'd247);
		for (int i = 0; i < 69; i++) body.push_back(8'($urandom()));
		send_frame(body, 1'b0);
		set_address(8'd0);
		body = '{8'd0, FC_READ_HOLD, 8'h00, 8'h00, 8'h00, 8'h02};
		send_frame(body, 1'b1);
		set_address(8'($urandom_range(1, 246)));

		// random part, with an address change every so often
		while (items_sent < 330) begin
			if ($urandom_range(39) == 0) begin
				set_address(($urandom_range(3) == 0) ? 8'($urandom_range(1) ? 1 : 247)
					: 8'($urandom_range(1, 247)));
			end
			calm = ($urandom_range(29) == 0) ? 1'b1 : (($urandom_range(9) == 0) ? 1'b0 : calm);
			random_request();
		end
		calm = 1'b0;
		rx_ch.valid <= 1'b0;

		// drain: wait for every expected byte, then let the engine settle
		while (pending_bytes != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// long receiver hold-off while frames keep coming in
	initial begin
		@(posedge arst_n);
		while (items_sent < 180) @(posedge clk);
		tx_hold <= 1'b1;
		repeat (800) @(posedge clk);
		tx_hold <= 1'b0;
	end

endmodule
`default_nettype wire
